[src/ogdi_pkg.sv]
// Shared types and constants for the occupancy grid disk inflation block.
package ogdi_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_RADIUS_DEF = 8;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 11;

    localparam logic [CFG_IW-1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RADIUS_CELLS = 2'd2;

    localparam logic [10:0] WIDTH_RST  = 11'd1024;
    localparam logic [10:0] HEIGHT_RST = 11'd1024;
    localparam logic [3:0]  RADIUS_RST = 4'd0;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ROW,
        ST_MUL_THR,
        ST_CMP,
        ST_CENTER,
        ST_SCAN,
        ST_FLUSH,
        ST_OUT
    } ogdi_state_t;

    typedef struct packed {
        logic take;
        logic mul_row;
        logic mul_thr;
        logic advance_in;
        logic center;
        logic scan;
        logic emit;
    } ogdi_cmd_t;

    typedef struct packed {
        logic op;
        logic all_in;
        logic ge;
        logic scan_end;
        logic out_free;
    } ogdi_status_t;

endpackage

[src/occupancy_grid_disk_inflation.sv]
// Top level of the occupancy grid disk inflation block.
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes grid_width (0),
//   grid_height (1) and radius_cells (2); cfg_ready is always high. Write only when idle.
//   Slave stream: tdata carries cell_value, tuser carries op (0 cell, 1 drain).
//   Master stream: tdata carries out_value, out_row, out_col; tlast marks the last cell.
//   Items are taken one at a time. A dropped cell or an ignored drain is taken in idle;
//   a cell that produces no result passes the multiply and compare states; a cell that
//   produces a result, and a drain, also run the centre, disk scan and flush states before
//   the next is taken, the disk scan reading the row store one entry per cycle. The result
//   is registered when the output state, after the flush state, emits it to the master side.
//   Cells are stored in a ring of 2*MAX_RADIUS+1 rows; a result for a cell leaves
//   once the cell r rows and r columns further on has arrived, drains flush the rest.
//   Reset restores width 1024, height 1024, radius 0 and an empty frame; the row store
//   needs no clearing. When the receiver stalls the result is held and the block still
//   takes the next item, but a second result waits until the first transaction completes.
module occupancy_grid_disk_inflation
#(
    parameter int MAX_WIDTH  = ogdi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ogdi_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = ogdi_pkg::MAX_RADIUS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ogdi_pkg::CFG_IW-1:0] cfg_index,
    input  logic [ogdi_pkg::CFG_DW-1:0] cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] cell_value
    input  logic                        s_tuser,   // [0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [7:0] out_value, [17:8] out_row, [27:18] out_col
    output logic                        m_tlast
);

    ogdi_pkg::ogdi_cmd_t    cmd;
    ogdi_pkg::ogdi_status_t sts;

    assign cfg_ready = 1'b1;

    ogdi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ogdi_dp
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_value  (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[src/ogdi_ctrl.sv]
// Sequencer for cell intake, lag test, disk scan and result hand-off.
module ogdi_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ogdi_pkg::ogdi_status_t sts,
    output ogdi_pkg::ogdi_cmd_t    cmd
);

    ogdi_pkg::ogdi_state_t state_reg;
    ogdi_pkg::ogdi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ogdi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ogdi_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    if (sts.all_in)
                    begin
                        if (sts.op == ogdi_pkg::OP_DRAIN)
                        begin
                            state_next = ogdi_pkg::ST_CENTER;
                        end
                    end
                    else if (sts.op == ogdi_pkg::OP_CELL)
                    begin
                        state_next = ogdi_pkg::ST_MUL_ROW;
                    end
                end
            end
            ogdi_pkg::ST_MUL_ROW:
            begin
                cmd.mul_row = 1'b1;
                state_next  = ogdi_pkg::ST_MUL_THR;
            end
            ogdi_pkg::ST_MUL_THR:
            begin
                cmd.mul_thr = 1'b1;
                state_next  = ogdi_pkg::ST_CMP;
            end
            ogdi_pkg::ST_CMP:
            begin
                if (sts.ge)
                begin
                    state_next = ogdi_pkg::ST_CENTER;
                end
                else
                begin
                    cmd.advance_in = 1'b1;
                    state_next     = ogdi_pkg::ST_IDLE;
                end
            end
            ogdi_pkg::ST_CENTER:
            begin
                cmd.center = 1'b1;
                state_next = ogdi_pkg::ST_SCAN;
            end
            ogdi_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = ogdi_pkg::ST_FLUSH;
                end
            end
            ogdi_pkg::ST_FLUSH:
            begin
                state_next = ogdi_pkg::ST_OUT;
            end
            ogdi_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ogdi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ogdi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/ogdi_dp.sv]
// Datapath: row store, position counters, lag test, disk scan and output register.
module ogdi_dp
#(
    parameter int MAX_WIDTH  = ogdi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ogdi_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = ogdi_pkg::MAX_RADIUS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [ogdi_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [ogdi_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                          in_op,
    input  logic [7:0]                    in_value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast,
    input  ogdi_pkg::ogdi_cmd_t           cmd,
    output ogdi_pkg::ogdi_status_t        sts
);

    localparam int SR    = 2 * MAX_RADIUS + 1;
    localparam int SW    = (SR > 1) ? $clog2(SR) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RDW   = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int DW    = RDW + 2;
    localparam int LW    = RW + WW + 4;
    localparam int YW    = RW + DW + 1;
    localparam int XW    = CW + DW + 1;
    localparam int SSW   = ((SW > DW) ? SW : DW) + 2;
    localparam int AW    = SW + CW;
    localparam int DEPTH = SR * (2 ** CW);
    localparam int QW    = 2 * DW + 1;

    logic [10:0]      width_reg;
    logic [10:0]      height_reg;
    logic [3:0]       radius_reg;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic [RDW-1:0]   eff_r;

    logic [RW-1:0]    in_row_reg;
    logic [CW-1:0]    in_col_reg;
    logic [SW-1:0]    in_slot_reg;
    logic [RW-1:0]    emit_row_reg;
    logic [CW-1:0]    emit_col_reg;
    logic [SW-1:0]    emit_slot_reg;
    logic             all_in_reg;
    logic             op_reg;

    logic signed [LW-1:0] prod_reg;
    logic signed [LW-1:0] thr_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] dx_reg;
    logic             pend_center_reg;
    logic             pend_win_reg;
    logic             blocked_reg;
    logic [7:0]       val_reg;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;

    logic             m_tvalid_reg;
    logic [7:0]       out_value_reg;
    logic [9:0]       out_row_reg;
    logic [9:0]       out_col_reg;
    logic             out_last_reg;

    logic             in_last;
    logic             emit_last;
    logic             center_ok;
    logic signed [DW-1:0] rs;
    logic signed [YW-1:0] y0;
    logic signed [XW-1:0] x0;
    logic signed [SSW-1:0] ssum;
    logic [SW-1:0]    win_slot;
    logic signed [2*DW-1:0] dxs;
    logic signed [2*DW-1:0] dys;
    logic [QW-1:0]    d2;
    logic [2*RDW-1:0] rr;
    logic             in_window;
    logic signed [LW-1:0] drow;
    logic signed [LW-1:0] dcol;

    // effective geometry
    always_comb
    begin
        if (width_reg == 11'd0)
            eff_w = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        if (height_reg == 11'd0)
            eff_h = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_reg);
        if (32'(radius_reg) > MAX_RADIUS)
            eff_r = RDW'(MAX_RADIUS);
        else
            eff_r = RDW'(radius_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ogdi_pkg::WIDTH_RST;
            height_reg <= ogdi_pkg::HEIGHT_RST;
            radius_reg <= ogdi_pkg::RADIUS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ogdi_pkg::CFG_GRID_WIDTH:   width_reg  <= cfg_data;
                ogdi_pkg::CFG_GRID_HEIGHT:  height_reg <= cfg_data;
                ogdi_pkg::CFG_RADIUS_CELLS: radius_reg <= cfg_data[3:0];
                default:                    ;
            endcase
        end
    end

    assign in_last   = (32'(in_row_reg) + 32'd1 >= 32'(eff_h))
                    && (32'(in_col_reg) + 32'd1 >= 32'(eff_w));
    assign emit_last = (32'(emit_row_reg) + 32'd1 >= 32'(eff_h))
                    && (32'(emit_col_reg) + 32'd1 >= 32'(eff_w));
    assign center_ok = (32'(emit_col_reg) < 32'(eff_w)) && (32'(emit_row_reg) < 32'(eff_h));

    // lag between intake and emission in raster positions
    assign drow = LW'(signed'({1'b0, in_row_reg})) - LW'(signed'({1'b0, emit_row_reg}));
    assign dcol = LW'(signed'({1'b0, in_col_reg})) - LW'(signed'({1'b0, emit_col_reg}));

    // window position
    assign rs   = signed'(DW'(eff_r));
    assign y0   = YW'(signed'({1'b0, emit_row_reg})) + YW'(dy_reg);
    assign x0   = XW'(signed'({1'b0, emit_col_reg})) + XW'(dx_reg);
    assign ssum = SSW'(signed'({1'b0, emit_slot_reg})) + SSW'(dy_reg);
    assign dxs  = dx_reg * dx_reg;
    assign dys  = dy_reg * dy_reg;
    assign d2   = QW'(unsigned'(dxs)) + QW'(unsigned'(dys));
    assign rr   = eff_r * eff_r;

    always_comb
    begin
        if (ssum < 0)
            win_slot = SW'(ssum + SSW'(SR));
        else if (ssum >= SSW'(SR))
            win_slot = SW'(ssum - SSW'(SR));
        else
            win_slot = SW'(ssum);
    end

    assign in_window = !y0[YW-1] && (y0 < YW'(eff_h))
                    && !x0[XW-1] && (x0 < XW'(eff_w))
                    && (d2 <= QW'(rr));

    // row store
    assign wr_en   = cmd.take && (in_op == ogdi_pkg::OP_CELL) && !all_in_reg;
    assign wr_addr = {in_slot_reg, in_col_reg};
    assign rd_addr = cmd.center ? {emit_slot_reg, emit_col_reg}
                                : {win_slot, CW'(x0)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // arithmetic and scan
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg <= in_op;
        end
        if (cmd.mul_row)
        begin
            prod_reg <= LW'(drow * LW'(signed'({1'b0, eff_w})));
        end
        if (cmd.mul_thr)
        begin
            thr_reg <= LW'(signed'({1'b0, eff_r})) * LW'(signed'({1'b0, eff_w}))
                     + LW'(signed'({1'b0, eff_r}));
        end
        if (cmd.center)
        begin
            dy_reg      <= -rs;
            dx_reg      <= -rs;
            blocked_reg <= 1'b0;
            if (!center_ok)
            begin
                val_reg <= 8'd0;
            end
        end
        else
        begin
            if (cmd.scan)
            begin
                if (dx_reg == rs)
                begin
                    dx_reg <= -rs;
                    dy_reg <= dy_reg + DW'(1);
                end
                else
                begin
                    dx_reg <= dx_reg + DW'(1);
                end
            end
            if (pend_win_reg && rd_data_reg == 8'd0)
            begin
                blocked_reg <= 1'b1;
            end
            if (pend_center_reg)
            begin
                val_reg <= rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_center_reg <= 1'b0;
            pend_win_reg    <= 1'b0;
        end
        else
        begin
            pend_center_reg <= cmd.center && center_ok;
            pend_win_reg    <= cmd.scan && in_window;
        end
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_slot_reg   <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_slot_reg <= '0;
            all_in_reg    <= 1'b0;
        end
        else if (cmd.emit && emit_last)
        begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_slot_reg   <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_slot_reg <= '0;
            all_in_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                if (32'(emit_col_reg) + 32'd1 >= 32'(eff_w))
                begin
                    emit_col_reg  <= '0;
                    emit_row_reg  <= emit_row_reg + RW'(1);
                    emit_slot_reg <= (emit_slot_reg == SW'(SR - 1)) ? '0
                                     : emit_slot_reg + SW'(1);
                end
                else
                begin
                    emit_col_reg <= emit_col_reg + CW'(1);
                end
            end
            if (cmd.advance_in || (cmd.emit && op_reg == ogdi_pkg::OP_CELL))
            begin
                if (in_last)
                begin
                    all_in_reg <= 1'b1;
                end
                else if (32'(in_col_reg) + 32'd1 >= 32'(eff_w))
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + RW'(1);
                    in_slot_reg <= (in_slot_reg == SW'(SR - 1)) ? '0
                                   : in_slot_reg + SW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg <= blocked_reg ? 8'd0 : val_reg;
            out_row_reg   <= 10'(emit_row_reg);
            out_col_reg   <= 10'(emit_col_reg);
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_col_reg, out_row_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

    assign sts.op       = in_op;
    assign sts.all_in   = all_in_reg;
    assign sts.ge       = (prod_reg + dcol) >= thr_reg;
    assign sts.scan_end = (dy_reg == rs) && (dx_reg == rs);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    a_slots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(in_slot_reg) < SR) && (32'(emit_slot_reg) < SR))
        else $error("row slot out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && emit_last) |=> (!all_in_reg && in_row_reg == '0 && emit_row_reg == '0))
        else $error("frame not cleared after last cell");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !all_in_reg)
        else $error("cell stored after frame complete");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the occupancy grid disk inflation block.
module testbench;

    localparam int STORE_ROWS = 2 * ogdi_pkg::MAX_RADIUS_DEF + 1;
    localparam int MAX_W = ogdi_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H = ogdi_pkg::MAX_HEIGHT_DEF;
    localparam int MAX_R = ogdi_pkg::MAX_RADIUS_DEF;
    localparam int IW = ogdi_pkg::CFG_IW;
    localparam int DWD = ogdi_pkg::CFG_DW;
    localparam int SETTLE_CYCLES = 320;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int CELLS_PER_PHASE = 90;
    localparam logic [IW-1:0] CFG_SPARE = 2'd3;
    localparam logic [IW-1:0] IX_W = ogdi_pkg::CFG_GRID_WIDTH;
    localparam logic [IW-1:0] IX_H = ogdi_pkg::CFG_GRID_HEIGHT;
    localparam logic [IW-1:0] IX_R = ogdi_pkg::CFG_RADIUS_CELLS;
    localparam logic OP_C = ogdi_pkg::OP_CELL;
    localparam logic OP_D = ogdi_pkg::OP_DRAIN;

    typedef struct packed {
        logic [7:0] value;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } cell_res_t;

    typedef struct packed {
        bit                is_cfg;
        bit [IW-1:0]       index;
        bit                op;
        bit [DWD-1:0]      data;
        bit                has_res;
        cell_res_t         res;
    } dir_row_t;

    localparam int N_DIR = 26;
    localparam dir_row_t DIRECTED [N_DIR] = '{
        '{1'b1, IX_W, OP_C, 11'd2,   1'b0, '0},
        '{1'b1, IX_H, OP_C, 11'd2,   1'b0, '0},
        '{1'b1, IX_R, OP_C, 11'd0,   1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd255, 1'b1, '{8'd255, 10'd0, 10'd0, 1'b0}},
        '{1'b0, IX_W, OP_C, 11'd0,   1'b1, '{8'd0,   10'd0, 10'd1, 1'b0}},
        '{1'b0, IX_W, OP_D, 11'd0,   1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd1,   1'b1, '{8'd1,   10'd1, 10'd0, 1'b0}},
        '{1'b0, IX_W, OP_C, 11'd128, 1'b1, '{8'd128, 10'd1, 10'd1, 1'b1}},
        '{1'b1, IX_W, OP_C, 11'd3,   1'b0, '0},
        '{1'b1, IX_H, OP_C, 11'd3,   1'b0, '0},
        '{1'b1, IX_R, OP_C, 11'd1,   1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd170, 1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd85,  1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd255, 1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd1,   1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd0,   1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd254, 1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd128, 1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd64,  1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd255, 1'b0, '0},
        '{1'b0, IX_W, OP_D, 11'd0,   1'b0, '0},
        '{1'b0, IX_W, OP_C, 11'd7,   1'b0, '0},
        '{1'b0, IX_W, OP_D, 11'd0,   1'b0, '0},
        '{1'b0, IX_W, OP_D, 11'd0,   1'b0, '0},
        '{1'b0, IX_W, OP_D, 11'd0,   1'b0, '0},
        '{1'b0, IX_W, OP_D, 11'd0,   1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IW-1:0]       cfg_index;
    logic [DWD-1:0]      cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                m_tlast;

    occupancy_grid_disk_inflation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state
    logic [7:0]  cell_store [STORE_ROWS*MAX_W];
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned radius_reg;
    int unsigned wr_row;
    int unsigned wr_col;
    int unsigned emit_row;
    int unsigned emit_col;
    bit          frame_in;
    int          frames_ended;
    cell_res_t   pending_cells [$];

    int          errors;
    int          cells_sent;
    int          results_checked;
    int          frames_done;
    int          send_idle_pct;
    int          recv_idle_pct;
    longint      cycles = 0;

    function automatic int grid_w();
        if (width_reg == 0) return 1;
        return width_reg > MAX_W ? MAX_W : int'(width_reg);
    endfunction

    function automatic int grid_h();
        if (height_reg == 0) return 1;
        return height_reg > MAX_H ? MAX_H : int'(height_reg);
    endfunction

    function automatic int disk_r();
        return radius_reg > MAX_R ? MAX_R : int'(radius_reg);
    endfunction

    function automatic logic [7:0] stored(int row, int col);
        return cell_store[(row % STORE_ROWS) * MAX_W + col];
    endfunction

    // Emits the inflated cell at the output position; returns 1 at frame end.
    function automatic bit emit_inflated();
        int        w;
        int        h;
        int        r;
        bit        blocked;
        bit        outside;
        cell_res_t res;
        w = grid_w();
        h = grid_h();
        r = disk_r();
        blocked = 0;
        for (int dy = -r; dy <= r; dy++)
            for (int dx = -r; dx <= r; dx++)
                if (int'(emit_row) + dy >= 0 && int'(emit_row) + dy < h &&
                    int'(emit_col) + dx >= 0 && int'(emit_col) + dx < w &&
                    dx * dx + dy * dy <= r * r &&
                    stored(emit_row + dy, emit_col + dx) == 8'd0)
                    blocked = 1;
        outside = (int'(emit_col) >= w) || (int'(emit_row) >= h);
        res.value = (blocked || outside) ? 8'd0 : stored(emit_row, emit_col);
        res.row   = emit_row[9:0];
        res.col   = emit_col[9:0];
        res.last  = (emit_row + 1 >= h) && (emit_col + 1 >= w);
        pending_cells.push_back(res);
        if (res.last) begin
            wr_row = 0;
            wr_col = 0;
            emit_row = 0;
            emit_col = 0;
            frame_in = 0;
            frames_ended++;
        end else if (emit_col + 1 >= w) begin
            emit_col = 0;
            emit_row++;
        end else begin
            emit_col++;
        end
        return res.last;
    endfunction

    function automatic void predict_item(logic op, logic [7:0] value);
        longint w;
        longint r;
        longint in_lin;
        longint out_lin;
        bit     in_last;
        if (op == OP_D) begin
            if (frame_in) void'(emit_inflated());
            return;
        end
        if (frame_in) return;
        w = grid_w();
        r = disk_r();
        cell_store[(wr_row % STORE_ROWS) * MAX_W + wr_col] = value;
        in_lin  = longint'(wr_row) * w + wr_col;
        out_lin = longint'(emit_row) * w + emit_col;
        in_last = (wr_row + 1 >= grid_h()) && (wr_col + 1 >= w);
        if (in_lin - out_lin >= r * w + r)
            if (emit_inflated()) return;
        if (in_last) begin
            frame_in = 1;
        end else if (wr_col + 1 >= w) begin
            wr_col = 0;
            wr_row++;
        end else begin
            wr_col++;
        end
    endfunction

    task automatic send_item(logic op, logic [7:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        predict_item(op, value);
        if (op == OP_C) cells_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IW-1:0] index, logic [DWD-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            IX_W:    width_reg  = 32'(data);
            IX_H:    height_reg = 32'(data);
            IX_R:    radius_reg = 32'(data[3:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic run_frame(int w, int h, int r);
        int start_frames;
        wait_idle();
        start_frames = frames_ended;
        write_reg(IX_W, w[DWD-1:0]);
        write_reg(IX_H, h[DWD-1:0]);
        write_reg(IX_R, r[DWD-1:0]);
        while (!frame_in && frames_ended == start_frames) begin
            if ($urandom_range(99) < 4) send_item(OP_D, 8'($urandom_range(255)));
            send_item(OP_C, ($urandom_range(99) < 8) ? 8'd0 : 8'($urandom_range(255)));
        end
        while (frame_in) begin
            if ($urandom_range(99) < 6) send_item(OP_C, 8'($urandom_range(255)));
            else send_item(OP_D, 8'($urandom_range(255)));
        end
        frames_done++;
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_cells.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected transaction tdata=%h tlast=%b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                cell_res_t exp_res;
                exp_res = pending_cells.pop_front();
                results_checked++;
                if (m_tdata[7:0] !== exp_res.value || m_tdata[17:8] !== exp_res.row ||
                    m_tdata[27:18] !== exp_res.col || m_tdata[31:28] !== 4'd0 ||
                    m_tlast !== exp_res.last) begin
                    $display("%0t: mismatch exp val=%0d row=%0d col=%0d last=%b", $time,
                             exp_res.value, exp_res.row, exp_res.col, exp_res.last);
                    $display("%0t:          act val=%0d row=%0d col=%0d last=%b pad=%h",
                             $time, m_tdata[7:0], m_tdata[17:8], m_tdata[27:18],
                             m_tlast, m_tdata[31:28]);
                    errors++;
                end
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_C;
        errors = 0;
        cells_sent = 0;
        results_checked = 0;
        frames_done = 0;
        frames_ended = 0;
        send_idle_pct = 14;
        recv_idle_pct = 79;
        width_reg = 32'(ogdi_pkg::WIDTH_RST);
        height_reg = 32'(ogdi_pkg::HEIGHT_RST);
        radius_reg = 32'(ogdi_pkg::RADIUS_RST);
        wr_row = 0;
        wr_col = 0;
        emit_row = 0;
        emit_col = 0;
        frame_in = 0;
        foreach (cell_store[i]) cell_store[i] = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_SPARE, 11'h7FF);
        for (int i = 0; i < N_DIR; i++) begin
            if (DIRECTED[i].is_cfg) begin
                wait_idle();
                write_reg(DIRECTED[i].index, DIRECTED[i].data);
            end else begin
                int before_cnt;
                before_cnt = pending_cells.size();
                send_item(DIRECTED[i].op, DIRECTED[i].data[7:0]);
                if (DIRECTED[i].has_res && pending_cells.size() == before_cnt + 1) begin
                    void'(pending_cells.pop_back());
                    pending_cells.push_back(DIRECTED[i].res);
                end
            end
        end
        frames_done = 2;
        cells_sent = 0;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 14 : 0;
            case (phase)
                0: run_frame(24, 2, 1);
                1: run_frame(1, 24, 2);
                default: run_frame(0, 0, 15);
            endcase
            run_frame(3, 3, 8);
            run_frame(16, 1, 0);
            while (cells_sent < (phase + 1) * CELLS_PER_PHASE)
                run_frame($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 15));
        end

        wait_idle();
        $display("Covered %0d frames, %0d cells sent, %0d results checked",
                 frames_done, cells_sent, results_checked);
        $display("Grids 1x1 to 24 on a side, zero sizes and oversized radius, stalls both sides");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
